// ===== hdl/pulse_dial_hook_detector_assert.svh =====
// assertion macros for the pulse dial and hook detector
// needs a clock named clk and an active-low reset named arst_n in the using scope
`ifndef PULSE_DIAL_HOOK_DETECTOR_ASSERT_SVH
`define PULSE_DIAL_HOOK_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PDHD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDHD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PDHD_ASSERT_IMP(label, ante, cons, msg)
`define PDHD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/pdhd_pkg.sv =====
// shared types and constants for the pulse dial and hook detector
// no dependencies
package pdhd_pkg;

	localparam int TICK_W    = 8;
	localparam int TIMER_W   = 16;
	localparam int PULSE_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MS          = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOOK_QUALIFY_MS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_TIMEOUT_MS = 2'd2;

	// reset values
	localparam logic [TICK_W-1:0]  TICK_MS_RST          = 8'd1;
	localparam logic [TIMER_W-1:0] HOOK_QUALIFY_MS_RST  = 16'd100;
	localparam logic [TIMER_W-1:0] DIGIT_TIMEOUT_MS_RST = 16'd200;

	typedef struct packed {
		logic [TICK_W-1:0]  tick_ms;
		logic [TIMER_W-1:0] hook_qualify_ms;
		logic [TIMER_W-1:0] digit_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic               phone_up;
		logic               hook_event;
		logic               digit_valid;
		logic [PULSE_W-1:0] digit_pulses;
	} result_t;

	// saturating add of the tick length onto a timer
	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
		input logic [TICK_W-1:0] b);
		logic [TIMER_W:0] s;
		s = {1'b0, a} + {{(TIMER_W+1-TICK_W){1'b0}}, b};
		return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
	endfunction

endpackage

// ===== hdl/pulse_dial_hook_detector.sv =====
// top level of the switch-hook supervisor and rotary pulse-dial decoder
// uses pdhd_pkg, pdhd_cfg, pdhd_core and pulse_dial_hook_detector_assert.svh
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------------
//  in      | in_valid/in_stall  | hook_level
//  out     | out_valid/out_stall| phone_up, hook_event, digit_valid, digit_pulses
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// one sample a cycle while out_stall is low: a transfer lands in the input register, then
// the hook and dial logic works on it as it moves on and writes the output register
// reset clears handshake state, timers, pulse count and loads register defaults
// out_stall holds the output register; in_stall rises only when the input register
// is full and cannot move on, so no transfer is lost or repeated
`include "pulse_dial_hook_detector_assert.svh"

module pulse_dial_hook_detector import pdhd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 hook_level,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 phone_up,
	output logic                 hook_event,
	output logic                 digit_valid,
	output logic [PULSE_W-1:0]   digit_pulses,
	// register writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    core_lifted;

	logic valid_s1;
	logic level_s1;
	logic out_valid_q;
	logic advance;
	logic in_xfer;

	// the input register moves on whenever the output register is free or being taken
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_xfer  = in_valid & ~in_stall;

	pdhd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state is updated exactly when a sample moves into the output register
	pdhd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res),
		.lifted (core_lifted)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			level_s1 <= hook_level;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign phone_up     = res_q.phone_up;
	assign hook_event   = res_q.hook_event;
	assign digit_valid  = res_q.digit_valid;
	assign digit_pulses = res_q.digit_pulses;

	// handset state only moves when a sample is processed
	`PDHD_ASSERT_NXT(a_lifted_hold, !advance, $stable(core_lifted), "handset state moved without a sample")
	// no back-pressure on the input while the output register is empty
	`PDHD_ASSERT_IMP(a_no_false_stall, !out_valid_q, !in_stall, "input stalled with empty output")
	// a finished digit always carries at least one pulse
	`PDHD_ASSERT_IMP(a_digit_nonzero, out_valid_q && res_q.digit_valid, res_q.digit_pulses != '0, "digit with no pulses")
	// the delivered handset state matches the core after each processed sample
	`PDHD_ASSERT_NXT(a_lifted_match, advance, res_q.phone_up == core_lifted, "output lifted disagrees with core")

endmodule

// ===== hdl/pdhd_cfg.sv =====
// configuration registers of the pulse dial and hook detector
// uses pdhd_pkg
module pdhd_cfg import pdhd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms          <= TICK_MS_RST;
			cfg_q.hook_qualify_ms  <= HOOK_QUALIFY_MS_RST;
			cfg_q.digit_timeout_ms <= DIGIT_TIMEOUT_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_MS:          cfg_q.tick_ms          <= cfg_data[TICK_W-1:0];
				REG_HOOK_QUALIFY_MS:  cfg_q.hook_qualify_ms  <= cfg_data[TIMER_W-1:0];
				REG_DIGIT_TIMEOUT_MS: cfg_q.digit_timeout_ms <= cfg_data[TIMER_W-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/pdhd_core.sv =====
// hook supervision and dial pulse counting, one tick per fire
// uses pdhd_pkg
module pdhd_core import pdhd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  logic    level,
	input  cfg_t    cfg,
	output result_t res,
	output logic    lifted
);

	logic               prev_q;
	logic [TIMER_W-1:0] static_q;
	logic               lifted_q;
	logic [PULSE_W-1:0] pulse_q;
	logic [TIMER_W-1:0] since_q;

	logic               steady_high, steady_low, rising;
	logic [TIMER_W-1:0] static_nxt, since_nxt, since_add;
	logic               lifted_nxt, qualified, evt, dvalid;
	logic [PULSE_W-1:0] pulse_nxt, dpulses;

	always_comb begin
		steady_high = level & prev_q;
		steady_low  = ~level & ~prev_q;
		rising      = level & ~prev_q;

		static_nxt = (steady_high | steady_low) ? sat_add(static_q, cfg.tick_ms) : '0;
		qualified  = static_nxt >= cfg.hook_qualify_ms;

		lifted_nxt = lifted_q;
		evt        = 1'b0;
		if (steady_high && qualified && !lifted_q) begin
			lifted_nxt = 1'b1;
			evt        = 1'b1;
		end else if (steady_low && qualified && lifted_q) begin
			lifted_nxt = 1'b0;
			evt        = 1'b1;
		end

		pulse_nxt = pulse_q;
		since_nxt = since_q;
		since_add = sat_add(since_q, cfg.tick_ms);
		dvalid    = 1'b0;
		dpulses   = '0;
		if (lifted_nxt) begin
			if (rising) begin
				if (pulse_q != PULSE_MAX)
					pulse_nxt = pulse_q + 1'b1;
				since_nxt = '0;
			end
			// rising and steady high never coincide
			if (steady_high && pulse_q != '0) begin
				since_nxt = since_add;
				if (since_add > cfg.digit_timeout_ms) begin
					dvalid    = 1'b1;
					dpulses   = pulse_q;
					pulse_nxt = '0;
					since_nxt = '0;
				end
			end
		end

		res.phone_up     = lifted_nxt;
		res.hook_event   = evt;
		res.digit_valid  = dvalid;
		res.digit_pulses = dpulses;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			static_q <= '0;
			lifted_q <= 1'b0;
			pulse_q  <= '0;
			since_q  <= '0;
		end else if (fire) begin
			prev_q   <= level;
			static_q <= static_nxt;
			lifted_q <= lifted_nxt;
			pulse_q  <= pulse_nxt;
			since_q  <= since_nxt;
		end
	end

	assign lifted = lifted_q;

endmodule

// ===== test/pulse_dial_hook_detector_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for pulse_dial_hook_detector: lifts, dialed digits, hang-ups
// depends on pdhd_pkg and the pulse_dial_hook_detector rtl, nothing else

module pulse_dial_hook_detector_tb;
	import pdhd_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_ITEMS  = 150;
	// longest hold we ever ask for, in ticks; keeps full-scale timers affordable
	localparam int HOLD_CAP    = 268;
	// write to an index with no register behind it, must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// tracks the line the way the block should and queues the per-tick outcome
	class hook_dial_scoreboard;
		cfg_t               settings;
		logic               last_level;
		logic [TIMER_W-1:0] steady_ms;
		logic [TIMER_W-1:0] since_rise_ms;
		logic               off_hook;
		logic [PULSE_W-1:0] pulses;
		result_t            dial_outcomes[$];
		int                 errors;
		int                 hook_changes;
		int                 digits;
		int                 ceiling_digits;
		int                 pinned_ticks;

		function new();
			settings      = '{TICK_MS_RST, HOOK_QUALIFY_MS_RST, DIGIT_TIMEOUT_MS_RST};
			last_level    = 1'b0;
			steady_ms     = '0;
			since_rise_ms = '0;
			off_hook      = 1'b0;
			pulses        = '0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_TICK_MS: settings.tick_ms = data[TICK_W-1:0];
				REG_HOOK_QUALIFY_MS: settings.hook_qualify_ms = data[TIMER_W-1:0];
				REG_DIGIT_TIMEOUT_MS: settings.digit_timeout_ms = data[TIMER_W-1:0];
				default: ;
			endcase
		endfunction

		// timers add one tick length and stick at full scale
		function logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t);
			logic [TIMER_W:0] sum;
			sum = {1'b0, t} + {{(TIMER_W+1-TICK_W){1'b0}}, settings.tick_ms};
			return (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[TIMER_W-1:0];
		endfunction

		function int outstanding();
			return dial_outcomes.size();
		endfunction

		function void note_sample(input logic level);
			result_t r;
			logic    up_steady;
			logic    down_steady;
			logic    rose;
			up_steady   = level & last_level;
			down_steady = ~level & ~last_level;
			rose        = level & ~last_level;
			last_level  = level;
			r = '0;

			if (up_steady | down_steady)
				steady_ms = timer_add(steady_ms);
			else
				steady_ms = '0;

			if (up_steady && steady_ms >= settings.hook_qualify_ms && !off_hook) begin
				off_hook = 1'b1;
				r.hook_event = 1'b1;
			end else if (down_steady && steady_ms >= settings.hook_qualify_ms && off_hook) begin
				off_hook = 1'b0;
				r.hook_event = 1'b1;
			end

			if (off_hook) begin
				if (rose) begin
					if (pulses != PULSE_MAX)
						pulses++;
					since_rise_ms = '0;
				end
				if (up_steady && pulses != 0) begin
					since_rise_ms = timer_add(since_rise_ms);
					if (since_rise_ms > settings.digit_timeout_ms) begin
						r.digit_valid  = 1'b1;
						r.digit_pulses = pulses;
						if (pulses == PULSE_MAX)
							ceiling_digits++;
						digits++;
						pulses        = '0;
						since_rise_ms = '0;
					end
				end
			end
			r.phone_up = off_hook;

			if (r.hook_event)
				hook_changes++;
			if (steady_ms == TIMER_MAX || since_rise_ms == TIMER_MAX)
				pinned_ticks++;
			dial_outcomes.push_back(r);
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (dial_outcomes.size() == 0) begin
				$display("%0t result with no sample outstanding: got %p", $time, got);
				errors++;
				return;
			end
			want = dial_outcomes.pop_front();
			if (got.phone_up !== want.phone_up) begin
				$display("%0t phone_up: expected %0b, got %0b", $time,
					want.phone_up, got.phone_up);
				errors++;
			end
			if (got.hook_event !== want.hook_event) begin
				$display("%0t hook_event: expected %0b, got %0b", $time,
					want.hook_event, got.hook_event);
				errors++;
			end
			if (got.digit_valid !== want.digit_valid) begin
				$display("%0t digit_valid: expected %0b, got %0b", $time,
					want.digit_valid, got.digit_valid);
				errors++;
			end
			if (got.digit_pulses !== want.digit_pulses) begin
				$display("%0t digit_pulses: expected %0d, got %0d", $time,
					want.digit_pulses, got.digit_pulses);
				errors++;
			end
		endfunction
	endclass

	// everything the block sees starts at a known value
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 hook_level = 1'b0;
	logic                 out_stall  = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;

	logic                 in_stall;
	logic                 out_valid;
	logic                 phone_up;
	logic                 hook_event;
	logic                 digit_valid;
	logic [PULSE_W-1:0]   digit_pulses;

	hook_dial_scoreboard sb = new();

	int items_sent       = 0;
	int settings_applied = 0;
	int cycle_count      = 0;
	int stall_left       = 0;
	bit src_idling       = 1'b0;
	bit sink_idling      = 1'b0;

	pulse_dial_hook_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.hook_level   (hook_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.phone_up     (phone_up),
		.hook_event   (hook_event),
		.digit_valid  (digit_valid),
		.digit_pulses (digit_pulses),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pulse_dial_hook_detector_tb: errors");
			$finish;
		end
	end

	// receiver back-pressure: random bursts of stalled cycles while sink_idling is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (sink_idling && $urandom_range(0, 6) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result transfer: values seen here are the ones from before this edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({phone_up, hook_event, digit_valid, digit_pulses});
	end

	// one sample transfer; valid stays up so back-to-back samples need no re-raise
	task automatic send_sample(input logic level);
		if (src_idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		hook_level <= level;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(level);
		items_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// only ever called with the block drained
	task automatic apply_settings(input int tick, input int qualify, input int timeout);
		logic [CFG_DAT_W-1:0] word;
		// junk in the unused upper bits of the tick length must be dropped
		word = CFG_DAT_W'($urandom);
		word[TICK_W-1:0] = tick[TICK_W-1:0];
		write_setting(REG_TICK_MS, word);
		write_setting(REG_HOOK_QUALIFY_MS, qualify[CFG_DAT_W-1:0]);
		write_setting(REG_DIGIT_TIMEOUT_MS, timeout[CFG_DAT_W-1:0]);
		if ($urandom_range(0, 1) == 1) begin
			word = CFG_DAT_W'($urandom);
			write_setting(REG_UNUSED, word);
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// ticks of steady level needed to cover ms at the current tick length
	function automatic int ticks_for(input int ms);
		int tick;
		int n;
		tick = int'(sb.settings.tick_ms);
		if (ms == 0)
			return 0;
		if (tick == 0)
			return 1;
		n = (ms + tick - 1) / tick;
		return (n > HOLD_CAP) ? HOLD_CAP : n;
	endfunction

	// a whole call: line noise, lift, some digits, then optionally hang up
	// digits of zero picks 1 to 3; now and then the timeout hold is skipped so
	// the next digit's pulses run straight on
	task automatic dial_call(input int digits, input bit hang_up);
		int q_ticks;
		int t_ticks;
		int reps;
		int n;
		q_ticks = ticks_for(int'(sb.settings.hook_qualify_ms));
		t_ticks = ticks_for(int'(sb.settings.digit_timeout_ms));
		src_idling  = (items_sent + TAIL_ITEMS < ITEM_TARGET) && $urandom_range(0, 2) != 0;
		sink_idling = (items_sent + TAIL_ITEMS < ITEM_TARGET) && $urandom_range(0, 2) != 0;

		repeat ($urandom_range(0, 5))
			send_sample(1'($urandom_range(0, 1)));
		send_sample(1'b0);
		repeat (q_ticks + 2 + $urandom_range(0, 1))
			send_sample(1'b1);

		reps = (digits == 0) ? $urandom_range(1, 3) : digits;
		repeat (reps) begin
			// sometimes enough pulses to run the count into its ceiling
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 10);
			repeat (n) begin
				// pulse lows and highs stay short of hang-up and digit timeout
				repeat ((q_ticks >= 2 && $urandom_range(0, 1) == 1) ? 2 : 1)
					send_sample(1'b0);
				repeat ((t_ticks >= 3 && $urandom_range(0, 1) == 1) ? 2 : 1)
					send_sample(1'b1);
			end
			if ($urandom_range(0, 5) != 0)
				repeat (t_ticks + 2 + $urandom_range(0, 1))
					send_sample(1'b1);
		end

		if (hang_up)
			repeat (q_ticks + 2 + $urandom_range(0, 1))
				send_sample(1'b0);
	endtask

	initial begin
		// opening lines run at the reset settings, second one after a rewrite
		logic [5:0]  reset_script;
		logic [11:0] short_call;
		int          tick;
		int          qualify;
		int          timeout;
		reset_script = 6'b011001;
		short_call   = 12'b111011111000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: qualify 100 ms at 1 ms per tick, so no lift yet
		for (int i = 5; i >= 0; i--)
			send_sample(reset_script[i]);
		hold_until_drained();

		// 50 ms ticks: lift on the second high, one-pulse digit, then hang up
		apply_settings(50, 100, 150);
		for (int i = 11; i >= 0; i--)
			send_sample(short_call[i]);
		hold_until_drained();

		// zero tick length: timers stand still, digits never time out and the
		// count rides through the hang-up into the next call
		apply_settings(0, 0, 0);
		dial_call(3, 1'b1);
		hold_until_drained();

		apply_settings(1, 0, 0);
		dial_call(0, 1'b1);
		hold_until_drained();

		// longest qualify: static timer has to pin at full scale to lift
		apply_settings(255, 65535, 0);
		dial_call(1, 1'b0);
		hold_until_drained();

		// longest digit timeout: the rise timer pins and the digit never ends
		apply_settings(255, 0, 65535);
		dial_call(1, 1'b1);
		hold_until_drained();

		// random settings, mostly a handful of ticks per qualify and timeout
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 15) == 0)
				tick = 0;
			else if ($urandom_range(0, 3) == 0)
				tick = 1;
			else
				tick = $urandom_range(1, 255);
			qualify = tick * $urandom_range(0, 10);
			timeout = tick * $urandom_range(0, 8);
			// off-grid values so the compares land between tick boundaries
			if (tick > 1 && $urandom_range(0, 1) == 1)
				qualify += $urandom_range(1, tick - 1);
			if (tick > 1 && $urandom_range(0, 1) == 1)
				timeout += $urandom_range(1, tick - 1);
			apply_settings(tick, qualify, timeout);
			repeat ($urandom_range(1, 3))
				dial_call(0, 1'b1);
			hold_until_drained();
		end

		src_idling  = 1'b0;
		sink_idling = 1'b0;
		hold_until_drained();
		// let any stray result show before the summary
		repeat (6) @(posedge clk);

		$display("covered %0d line samples over %0d register settings, %0d lift/hang-up changes",
			items_sent, settings_applied + 1, sb.hook_changes);
		$display("%0d digits decoded, %0d at the pulse ceiling, %0d ticks with a timer pinned",
			sb.digits, sb.ceiling_digits, sb.pinned_ticks);
		if (sb.errors == 0)
			$display("pulse_dial_hook_detector_tb: clean");
		else
			$display("pulse_dial_hook_detector_tb: errors");
		$finish;
	end

endmodule
